[rtl/sfd_pkg.sv]
`timescale 1ns / 1ps
// Package for the serial frame deframer: result kinds, register indexes,
// configuration and queue item types. No dependencies.
package sfd_pkg;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_GOOD = 2'd1,
    KIND_BAD  = 2'd2
  } sfd_kind_e;

  localparam int unsigned CfgAddrW = 3;

  localparam logic [CfgAddrW-1:0] REG_PROTOCOL_MODE  = 3'd0;
  localparam logic [CfgAddrW-1:0] REG_CLASSIC_START  = 3'd1;
  localparam logic [CfgAddrW-1:0] REG_FRAME_OPEN     = 3'd2;
  localparam logic [CfgAddrW-1:0] REG_FRAME_CLOSE    = 3'd3;
  localparam logic [CfgAddrW-1:0] REG_ESCAPE_VALUE   = 3'd4;

  localparam logic [7:0] CSUM_SEED = 8'd10;

  // Result queue between front and back
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef struct packed {
    logic       protocol_mode;
    logic [7:0] classic_start_byte;
    logic [7:0] frame_open_byte;
    logic [7:0] frame_close_byte;
    logic [7:0] escape_value;
  } sfd_cfg_t;

  typedef struct packed {
    sfd_kind_e   kind;
    logic [7:0]  data;
    logic [7:0]  index;
    logic [15:0] err_count;
  } sfd_item_t;

endpackage

[rtl/sfd_front.sv]
`timescale 1ns / 1ps
// Deframer front end: takes each received byte, updates the frame state and
// builds the result item, if any. Depends on sfd_pkg.
module sfd_front import sfd_pkg::*; #(
  parameter int unsigned FRAME_BYTES = 17
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  sfd_cfg_t   cfg_i,
  input  logic       take_i,
  input  logic [7:0] rx_byte_i,
  output logic       push_o,
  output sfd_item_t  item_o
);

  localparam logic [7:0] PayloadLast = 8'(FRAME_BYTES - 1);

  logic        in_frame_q, in_frame_d;
  logic        esc_q, esc_d;
  logic [7:0]  count_q, count_d;
  logic [7:0]  sum_q, sum_d;
  logic [7:0]  last_q, last_d;
  logic [15:0] bad_q, bad_d;

  logic        emit;
  logic        do_store;
  logic        do_verdict;
  logic        good;
  logic [7:0]  store_val;
  logic [7:0]  verdict_data;
  logic [7:0]  before_last;

  assign before_last = sum_q - last_q;

  always_comb begin
    in_frame_d   = in_frame_q;
    esc_d        = esc_q;
    count_d      = count_q;
    sum_d        = sum_q;
    last_d       = last_q;
    bad_d        = bad_q;
    do_store     = 1'b0;
    do_verdict   = 1'b0;
    good         = 1'b0;
    store_val    = rx_byte_i;
    verdict_data = rx_byte_i;

    if (!cfg_i.protocol_mode) begin
      if (!in_frame_q) begin
        if (rx_byte_i == cfg_i.classic_start_byte) begin
          in_frame_d = 1'b1;
          count_d    = '0;
          sum_d      = '0;
          last_d     = '0;
        end
      end else if (count_q < PayloadLast) begin
        do_store = 1'b1;
      end else begin
        in_frame_d = 1'b0;
        do_verdict = 1'b1;
        good       = (CSUM_SEED + sum_q) == rx_byte_i;
      end
    end else begin
      priority if (rx_byte_i == cfg_i.frame_open_byte) begin
        count_d = '0;
        sum_d   = '0;
        last_d  = '0;
        esc_d   = 1'b0;
      end else if (rx_byte_i == cfg_i.frame_close_byte) begin
        esc_d      = 1'b0;
        do_verdict = 1'b1;
        if (count_q == '0) begin
          verdict_data = '0;
        end else begin
          verdict_data = last_q;
          good         = (CSUM_SEED + before_last) == last_q;
        end
      end else if (esc_q) begin
        esc_d     = 1'b0;
        do_store  = 1'b1;
        store_val = rx_byte_i + cfg_i.escape_value;
      end else if (rx_byte_i == cfg_i.escape_value) begin
        esc_d = 1'b1;
      end else begin
        do_store = 1'b1;
      end
    end

    if (do_store) begin
      sum_d  = sum_q + store_val;
      last_d = store_val;
      if (count_q != 8'hFF) begin
        count_d = count_q + 8'd1;
      end
    end
    if (do_verdict && !good && (bad_q != 16'hFFFF)) begin
      bad_d = bad_q + 16'd1;
    end
  end

  assign emit   = do_store || do_verdict;
  assign push_o = take_i && emit;

  always_comb begin
    item_o.index     = count_q;
    item_o.err_count = bad_d;
    if (do_store) begin
      item_o.kind = KIND_DATA;
      item_o.data = store_val;
    end else begin
      item_o.kind = good ? KIND_GOOD : KIND_BAD;
      item_o.data = verdict_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      esc_q      <= 1'b1;
      count_q    <= '0;
      sum_q      <= '0;
      last_q     <= '0;
      bad_q      <= '0;
    end else if (take_i) begin
      in_frame_q <= in_frame_d;
      esc_q      <= esc_d;
      count_q    <= count_d;
      sum_q      <= sum_d;
      last_q     <= last_d;
      bad_q      <= bad_d;
    end
  end

endmodule

[rtl/sfd_queue.sv]
`timescale 1ns / 1ps
// Short result queue between deframer front and output stage.
// Depends on sfd_pkg for the item type and depth.
module sfd_queue import sfd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  sfd_item_t        push_item_i,
  input  logic             pop_i,
  output logic             not_empty_o,
  output logic             full_o,
  output logic [QCntW-1:0] level_o,
  output sfd_item_t        head_o
);

  sfd_item_t        mem [QDepth];
  logic [QPtrW-1:0] wr_q, wr_d;
  logic [QPtrW-1:0] rd_q, rd_d;
  logic [QCntW-1:0] cnt_q, cnt_d;

  function automatic logic [QPtrW-1:0] next_ptr(input logic [QPtrW-1:0] p);
    logic [QPtrW-1:0] r;
    r = (p == QPtrW'(QDepth - 1)) ? '0 : p + QPtrW'(1);
    return r;
  endfunction

  always_comb begin
    wr_d  = push_i ? next_ptr(wr_q) : wr_q;
    rd_d  = pop_i ? next_ptr(rd_q) : rd_q;
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  assign not_empty_o = cnt_q != '0;
  assign full_o      = cnt_q == QCntW'(QDepth);
  assign level_o     = cnt_q;
  assign head_o      = mem[rd_q];

endmodule

[rtl/sfd_back.sv]
`timescale 1ns / 1ps
// Output stage: pulls results from the queue into a register that holds
// while the receiver stalls. Depends on sfd_pkg.
module sfd_back import sfd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_not_empty_i,
  input  sfd_item_t q_head_i,
  output logic      q_pop_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output sfd_item_t out_item_o
);

  logic      valid_q, valid_d;
  sfd_item_t item_q;

  assign q_pop_o = q_not_empty_i && (!valid_q || out_ready_i);

  always_comb begin
    valid_d = valid_q;
    if (q_pop_o) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      item_q <= q_head_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule

[rtl/serial_frame_deframer_checksum.sv]
`timescale 1ns / 1ps
// Serial frame deframer with additive checksum, top level.
// Uses sfd_pkg, sfd_front, sfd_queue and sfd_back.
//
// Input channel: one received byte per transfer (rx_byte_i, in_valid_i /
// in_ready_o). Output channel: zero or one result per input byte
// (result_kind_o, data_byte_o, byte_index_o, error_count_o with
// out_valid_o / out_ready_i). Results leave in input order.
// Classic mode: a start byte opens a frame, FRAME_BYTES-1 payload bytes follow,
// then a checksum byte compared against 10 + 8-bit payload sum.
// Escaped mode: open/close bytes frame the data, an escape marker adds its
// value to the next byte; the last stored byte is the checksum.
// Throughput: one byte per cycle while in_ready_o is high. The front end updates
// the frame state as each byte is taken, so the next byte may follow at once.
// Path: a result is written into the queue when its byte is taken, then moved
// into the output register, from which it is shown.
// Stalls: the output register holds while out_ready_i is low; the two-entry
// queue absorbs results in flight and in_ready_o drops only when it is full.
// Reset: rst_ni zeroes registers and frame state except the escape flag, which
// starts set; hunting in classic mode, empty queue and no result shown.
// Configuration: cfg_we_i writes cfg_wdata_i to register cfg_addr_i
// (0 mode, 1 classic start, 2 open, 3 close, 4 escape); other indexes ignored.
module serial_frame_deframer_checksum import sfd_pkg::*; #(
  parameter int unsigned FRAME_BYTES = 17
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [7:0]          cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          rx_byte_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          result_kind_o,
  output logic [7:0]          data_byte_o,
  output logic [7:0]          byte_index_o,
  output logic [15:0]         error_count_o
);

  sfd_cfg_t         cfg_q;
  logic             take;
  logic             push;
  sfd_item_t        push_item;
  logic             pop;
  logic             q_not_empty;
  logic             q_full;
  logic [QCntW-1:0] q_level;
  sfd_item_t        q_head;
  sfd_item_t        out_item;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_PROTOCOL_MODE: cfg_q.protocol_mode      <= cfg_wdata_i[0];
        REG_CLASSIC_START: cfg_q.classic_start_byte <= cfg_wdata_i;
        REG_FRAME_OPEN:    cfg_q.frame_open_byte    <= cfg_wdata_i;
        REG_FRAME_CLOSE:   cfg_q.frame_close_byte   <= cfg_wdata_i;
        REG_ESCAPE_VALUE:  cfg_q.escape_value       <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Accept a byte whenever the queue has room for its result
  assign in_ready_o = !q_full;
  assign take       = in_valid_i && in_ready_o;

  sfd_front #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .take_i    (take),
    .rx_byte_i (rx_byte_i),
    .push_o    (push),
    .item_o    (push_item)
  );

  sfd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .not_empty_o (q_not_empty),
    .full_o      (q_full),
    .level_o     (q_level),
    .head_o      (q_head)
  );

  sfd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_not_empty_i (q_not_empty),
    .q_head_i      (q_head),
    .q_pop_o       (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_item_o    (out_item)
  );

  assign result_kind_o = out_item.kind;
  assign data_byte_o   = out_item.data;
  assign byte_index_o  = out_item.index;
  assign error_count_o = out_item.err_count;

`ifndef SYNTHESIS
  // Queue occupancy never passes its depth
  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_level <= QCntW'(QDepth))
    else $error("result queue overflow");

  // A result is only pushed when the queue has room
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_full)
    else $error("push into full queue");

  // A stored-byte result never raises the bad-frame count
  a_data_no_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && q_head.kind == KIND_DATA && out_valid_o)
      |-> q_head.err_count == out_item.err_count)
    else $error("error count changed on data result");
`endif

endmodule
